// File: rtl/bic_pkg.sv
package bic_pkg;

   // Register window layout within one bank
   localparam int unsigned SRC_PER_BANK = 32;
   localparam int unsigned OFF_W        = 6;

   localparam logic [OFF_W-1:0] OFF_SOURCE   = 6'h00;
   localparam logic [OFF_W-1:0] OFF_MASK     = 6'h04;
   localparam logic [OFF_W-1:0] OFF_MASK_SET = 6'h08;
   localparam logic [OFF_W-1:0] OFF_MASK_CLR = 6'h0C;
   localparam logic [OFF_W-1:0] OFF_PENDING  = 6'h10;

   localparam logic [31:0] POISON_WORD = 32'hDEAD_BEEF;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

   // Request kinds carried in req_type
   typedef enum logic [1:0] {
      REQ_LINE  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   // Read data source
   typedef enum logic [1:0] {
      RD_SOURCE,
      RD_MASK,
      RD_PENDING,
      RD_POISON
   } rd_sel_type;

   // Decoded command for one request
   typedef struct packed {
      logic       line_op;
      logic       line_level;
      logic       line_bank;
      logic [31:0] line_bit;
      logic       is_read;
      rd_sel_type rd_sel;
      logic       addr_bank;
      logic       mask_set;
      logic       mask_clr;
   } bic_cmd_type;

endpackage

// File: rtl/bic_req_if.sv
interface bic_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [5:0]  line_number;
   logic        line_level;
   logic [5:0]  reg_address;
   logic [31:0] write_value;

   modport source (
      output valid, req_type, line_number, line_level, reg_address, write_value,
      input  ready
   );

   modport sink (
      input  valid, req_type, line_number, line_level, reg_address, write_value,
      output ready
   );
endinterface

// File: rtl/bic_rsp_if.sv
interface bic_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_value;
   logic        irq_out;

   modport source (
      output valid, read_value, irq_out,
      input  ready
   );

   modport sink (
      input  valid, read_value, irq_out,
      output ready
   );
endinterface

// File: rtl/bic_decode.sv
module bic_decode
   import bic_pkg::*;
#(
   parameter int unsigned NUM_BANKS   = 2,
   parameter int unsigned BANK_STRIDE = 32
) (
   input  logic [1:0]  req_type,
   input  logic [5:0]  line_number,
   input  logic        line_level,
   input  logic [5:0]  reg_address,
   output bic_cmd_type cmd
);

   localparam logic [3:0] NUM_BANKS_W = 4'(NUM_BANKS);
   localparam logic [8:0] STRIDE_W    = 9'(BANK_STRIDE);

   logic             addr_hi;
   logic [8:0]       off_wide;
   logic [OFF_W-1:0] offset;
   logic             line_ok;
   logic             addr_ok;

   // Split the byte offset into bank and register; a 6-bit offset spans at most two banks
   assign addr_hi  = {3'b000, reg_address} >= STRIDE_W;
   assign off_wide = {3'b000, reg_address} - (addr_hi ? STRIDE_W : 9'd0);
   assign offset   = off_wide[OFF_W-1:0];
   assign addr_ok  = {3'b000, addr_hi} < NUM_BANKS_W;

   // Line number: upper bit picks the bank, low five bits the source
   assign line_ok = {3'b000, line_number[5]} < NUM_BANKS_W;

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = RD_POISON;
      cmd.line_level = line_level;
      cmd.line_bank  = line_number[5];
      cmd.line_bit   = 32'd1 << line_number[4:0];
      cmd.addr_bank  = addr_hi;
      case (req_type)
         REQ_LINE: begin
            cmd.line_op = line_ok;
         end
         REQ_READ: begin
            cmd.is_read = 1'b1;
            if (addr_ok) begin
               if (offset == OFF_SOURCE) begin
                  cmd.rd_sel = RD_SOURCE;
               end else if (offset == OFF_MASK) begin
                  cmd.rd_sel = RD_MASK;
               end else if (offset == OFF_PENDING) begin
                  cmd.rd_sel = RD_PENDING;
               end
            end
         end
         REQ_WRITE: begin
            cmd.mask_set = addr_ok && (offset == OFF_MASK_SET);
            cmd.mask_clr = addr_ok && (offset == OFF_MASK_CLR);
         end
         default: begin
            cmd.line_op = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/banked_interrupt_controller_unit.sv
// Banked interrupt controller: NUM_BANKS banks of 32 sources, each with a
// level word and a mask word (mask resets to all ones, so every source starts
// masked). A request is a line change, a bus read or a mask set/clear write;
// each request produces exactly one response carrying the read data (zero for
// non-reads, 0xDEADBEEF for unknown offsets or banks) and the summary irq_out
// as it stands after that request. One request is accepted every cycle while
// the response is not stalled; a request passes from the input register through
// one pass of decode, bank update and pending OR into the response register.
// A stalled response holds the pipe but the input register still takes a
// request when it is free. No clearing pass after reset.
module banked_interrupt_controller_unit
   import bic_pkg::*;
#(
   parameter int unsigned NUM_BANKS   = 2,
   parameter int unsigned BANK_STRIDE = 32
) (
   input  logic       clock,
   input  logic       reset,
   bic_req_if.sink    req_if,
   bic_rsp_if.source  rsp_if
);

   // Input register
   logic        s1_valid_ff;
   logic [1:0]  s1_type_ff;
   logic [5:0]  s1_line_ff;
   logic        s1_level_ff;
   logic [5:0]  s1_addr_ff;
   logic [31:0] s1_data_ff;

   // Response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [31:0] rsp_value_in;
   logic        rsp_irq_ff;
   logic        rsp_irq_in;

   // Bank state
   logic [NUM_BANKS-1:0][31:0] src_ff;
   logic [NUM_BANKS-1:0][31:0] src_in;
   logic [NUM_BANKS-1:0][31:0] mask_ff;
   logic [NUM_BANKS-1:0][31:0] mask_in;

   logic        advance;
   logic        s1_take;
   bic_cmd_type cmd;
   logic [31:0] rd_src;
   logic [31:0] rd_mask;
   logic [31:0] pend_now;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign s1_take      = req_if.valid && req_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;

   // Capture a request on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_type_ff  <= req_if.req_type;
         s1_line_ff  <= req_if.line_number;
         s1_level_ff <= req_if.line_level;
         s1_addr_ff  <= req_if.reg_address;
         s1_data_ff  <= req_if.write_value;
      end
   end

   bic_decode #(
      .NUM_BANKS   (NUM_BANKS),
      .BANK_STRIDE (BANK_STRIDE)
   ) u_decode (
      .req_type    (s1_type_ff),
      .line_number (s1_line_ff),
      .line_level  (s1_level_ff),
      .reg_address (s1_addr_ff),
      .cmd         (cmd)
   );

   // Next bank state, read mux and summary OR
   always_comb begin
      rd_src     = '0;
      rd_mask    = '0;
      pend_now   = '0;
      rsp_irq_in = 1'b0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         src_in[b]  = src_ff[b];
         mask_in[b] = mask_ff[b];
         if (cmd.line_op && ({31'd0, cmd.line_bank} == 32'(b))) begin
            if (cmd.line_level) begin
               src_in[b] = src_ff[b] | cmd.line_bit;
            end else begin
               src_in[b] = src_ff[b] & ~cmd.line_bit;
            end
         end
         if ({31'd0, cmd.addr_bank} == 32'(b)) begin
            if (cmd.mask_set) begin
               mask_in[b] = mask_ff[b] | s1_data_ff;
            end else if (cmd.mask_clr) begin
               mask_in[b] = mask_ff[b] & ~s1_data_ff;
            end
            rd_src  = src_ff[b];
            rd_mask = mask_ff[b];
         end
         pend_now   = pend_now | (src_ff[b] & ~mask_ff[b]);
         rsp_irq_in = rsp_irq_in | (|(src_in[b] & ~mask_in[b]));
      end

      rsp_value_in = '0;
      if (cmd.is_read) begin
         case (cmd.rd_sel)
            RD_SOURCE:  rsp_value_in = rd_src;
            RD_MASK:    rsp_value_in = rd_mask;
            RD_PENDING: rsp_value_in = rd_src & ~rd_mask;
            default:    rsp_value_in = POISON_WORD;
         endcase
      end
   end

   // Commit bank state as the request moves into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            src_ff[b]  <= '0;
            mask_ff[b] <= ALL_ONES;
         end
      end else if (advance) begin
         src_ff  <= src_in;
         mask_ff <= mask_in;
      end
   end

   // Hold the response until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_irq_ff   <= rsp_irq_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = rsp_value_ff;
   assign rsp_if.irq_out    = rsp_irq_ff;

`ifndef SYNTHESIS
   // Summary in the response matches the committed bank state
   a_irq_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_irq_ff == (|pend_now)))
      else $error("irq_out does not match committed pending state");

   // Line changes leave the masks alone
   a_line_keeps_mask: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd.line_op) |=> $stable(mask_ff))
      else $error("line change altered a mask word");

   // Reads change no state
   a_read_no_side_effect: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd.is_read) |=> ($stable(src_ff) && $stable(mask_ff)))
      else $error("bus read altered bank state");

   // Non-read responses carry zero data
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && !cmd.is_read) |=> (rsp_value_ff == 32'd0))
      else $error("non-read response carries data");
`endif

endmodule
